// ===== rtl/mrp_pkg.sv =====
// shared types, codes and geometry helpers for the maxrects rectangle packer
// depends on nothing; imported by every module of the block
package mrp_pkg;

  localparam int COORD_BITS     = 13;
  localparam int MAX_FREE_RECTS = 64;
  localparam int MAX_USED_RECTS = 256;

  localparam int FREE_IW  = $clog2(MAX_FREE_RECTS);
  localparam int FREE_CW  = $clog2(MAX_FREE_RECTS + 1);
  localparam int USED_IW  = $clog2(MAX_USED_RECTS);
  localparam int USED_CW  = $clog2(MAX_USED_RECTS + 1);
  localparam int AREA_W   = 2 * COORD_BITS;
  localparam int TERM_W   = COORD_BITS + 1;
  localparam int SCORE_W  = COORD_BITS + USED_CW + 2;
  localparam int KEY_W    = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;

  typedef logic [COORD_BITS-1:0] coord_t;

  localparam coord_t MAX_COORD     = coord_t'(1 << (COORD_BITS - 1));
  localparam coord_t RESET_ATLAS_W = coord_t'(1024);
  localparam coord_t RESET_ATLAS_H = coord_t'(1024);

  localparam logic [2:0] MODE_SHORT   = 3'd0;
  localparam logic [2:0] MODE_LONG    = 3'd1;
  localparam logic [2:0] MODE_AREA    = 3'd2;
  localparam logic [2:0] MODE_TOPLEFT = 3'd3;
  localparam logic [2:0] MODE_CONTACT = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_SPILL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLASW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLASH = 8'd3;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } rect_t;

  typedef struct packed {
    logic   kind;
    coord_t item_width;
    coord_t item_height;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    coord_t     pos_x;
    coord_t     pos_y;
    logic       rotated;
  } out_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       rot;
    coord_t     atlas_w;
    coord_t     atlas_h;
  } cfg_t;

  function automatic coord_t clamp_dim(input coord_t v);
    return (v > MAX_COORD) ? MAX_COORD : v;
  endfunction

  function automatic coord_t overlap_len(input coord_t a0, input coord_t a1,
                                         input coord_t b0, input coord_t b1);
    coord_t lo;
    coord_t hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    if (a1 < b0 || b1 < a0) return '0;
    return coord_t'(hi - lo);
  endfunction

  // contact length of one used rect against candidate (x,y,w,h)
  function automatic logic [TERM_W-1:0] contact_term(input rect_t u, input coord_t x,
                                                     input coord_t y, input coord_t w,
                                                     input coord_t h);
    coord_t ex;
    coord_t ey;
    logic [TERM_W-1:0] s;
    ex = coord_t'(x + w);
    ey = coord_t'(y + h);
    s  = '0;
    if (u.l == ex || u.r == x) s = s + TERM_W'(overlap_len(u.t, u.b, y, ey));
    if (u.t == ey || u.b == y) s = s + TERM_W'(overlap_len(u.l, u.r, x, ex));
    return s;
  endfunction

  function automatic logic rect_hits(input rect_t f, input rect_t u);
    return !(u.l >= f.r || u.r <= f.l || u.t >= f.b || u.b <= f.t);
  endfunction

  function automatic logic rect_inside(input rect_t a, input rect_t b);
    return a.l >= b.l && a.t >= b.t && a.r <= b.r && a.b <= b.b;
  endfunction

  // split part k: above, below, left, right of u
  function automatic logic push_cond(input rect_t f, input rect_t u, input logic [1:0] k);
    logic c;
    unique case (k)
      2'd0: c = (u.t > f.t) && (u.t < f.b);
      2'd1: c = (u.b < f.b);
      2'd2: c = (u.l > f.l) && (u.l < f.r);
      default: c = (u.r < f.r);
    endcase
    return c;
  endfunction

  function automatic rect_t push_rect(input rect_t f, input rect_t u, input logic [1:0] k);
    rect_t n;
    n = f;
    unique case (k)
      2'd0: n.b = u.t;
      2'd1: n.t = u.b;
      2'd2: n.r = u.l;
      default: n.l = u.r;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/mrp_score.sv =====
// candidate scoring unit: fit check and ordering keys for one placement try
// depends on mrp_pkg
module mrp_score import mrp_pkg::*; (
  input  rect_t              f,
  input  coord_t             cw,
  input  coord_t             ch,
  input  logic [AREA_W-1:0]  area,
  input  logic [AREA_W-1:0]  iwih,
  input  logic [SCORE_W-1:0] score,
  input  logic [2:0]         mode,
  output logic               fit,
  output logic [KEY_W-1:0]   key1,
  output coord_t             key2
);

  coord_t fw;
  coord_t fh;
  coord_t dx;
  coord_t dy;
  coord_t sh;
  coord_t lg;

  always_comb begin
    fw  = coord_t'(f.r - f.l);
    fh  = coord_t'(f.b - f.t);
    fit = !(cw > fw || ch > fh);
    dx  = coord_t'(fw - cw);
    dy  = coord_t'(fh - ch);
    sh  = (dx < dy) ? dx : dy;
    lg  = (dx < dy) ? dy : dx;
    unique case (mode)
      MODE_SHORT: begin
        key1 = KEY_W'(sh);
        key2 = lg;
      end
      MODE_LONG: begin
        key1 = KEY_W'(lg);
        key2 = sh;
      end
      MODE_AREA: begin
        key1 = KEY_W'(AREA_W'(area - iwih));
        key2 = sh;
      end
      MODE_CONTACT: begin
        key1 = {KEY_W{1'b1}} - KEY_W'(score);
        key2 = '0;
      end
      default: begin
        key1 = KEY_W'({1'b0, f.t} + {1'b0, ch});
        key2 = f.l;
      end
    endcase
  end

endmodule

// ===== rtl/mrp_engine.sv =====
// sequencer with free, split, push and used tables: scan, contact, split, copy, prune, compact, record
// depends on mrp_pkg and mrp_score
module mrp_engine import mrp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  start,
  input  in_t   in_word,
  output logic  ready,
  output logic  res_valid,
  output out_t  res_word,
  input  logic  res_take
);

  typedef enum logic [18:0] {
    S_INIT    = 19'h00001,
    S_IDLE    = 19'h00002,
    S_SC_RD   = 19'h00004,
    S_SC_LAT  = 19'h00008,
    S_SC_CAND = 19'h00010,
    S_CT      = 19'h00020,
    S_SP_RD   = 19'h00040,
    S_SP_EVAL = 19'h00080,
    S_SP_PUSH = 19'h00100,
    S_CP_RD   = 19'h00200,
    S_CP_WR   = 19'h00400,
    S_PI_RD   = 19'h00800,
    S_PI_LAT  = 19'h01000,
    S_PJ_RD   = 19'h02000,
    S_PJ_EVAL = 19'h04000,
    S_KC_RD   = 19'h08000,
    S_KC_WR   = 19'h10000,
    S_REC     = 19'h20000,
    S_DONE    = 19'h40000
  } state_t;

  // tables
  rect_t a_mem [MAX_FREE_RECTS];
  rect_t b_mem [MAX_FREE_RECTS];
  rect_t p_mem [MAX_FREE_RECTS];
  rect_t u_mem [MAX_USED_RECTS];
  rect_t a_rd_r, b_rd_r, p_rd_r, u_rd_r;
  logic a_we, b_we, p_we, u_we;
  logic [FREE_IW-1:0] a_wa, a_ra, b_wa, b_ra, p_wa, p_ra;
  logic [USED_IW-1:0] u_wa, u_ra;
  rect_t a_wd, b_wd, p_wd, u_wd;

  state_t state_r, state_nxt;
  logic [FREE_CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [FREE_CW-1:0] cnt_r, cnt_nxt, run_r, run_nxt;
  logic [FREE_CW-1:0] scnt_r, scnt_nxt, pcnt_r, pcnt_nxt;
  logic [USED_CW-1:0] ucnt_r, ucnt_nxt, uidx_r, uidx_nxt;
  logic [1:0] k_r, k_nxt;
  logic o_r, o_nxt, found_r, found_nxt, rot_r, rot_nxt;
  logic pend_r, pend_nxt, spill_r, spill_nxt;
  logic [KEY_W-1:0] best1_r, best1_nxt;
  coord_t best2_r, best2_nxt;
  rect_t pick_r, pick_nxt, f_r, f_nxt, ei_r, ei_nxt;
  logic [AREA_W-1:0] area_r, area_nxt, iwih_r, iwih_nxt;
  coord_t iw_r, iw_nxt, ih_r, ih_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [MAX_FREE_RECTS-1:0] dead_r, dead_nxt;
  out_t res_r, res_nxt;

  coord_t cw, ch, fw0, fh0, ex, ey;
  logic sc_fit;
  logic [KEY_W-1:0] sc_key1;
  coord_t sc_key2;
  logic cand_fin, adv, pc, inc, dec;
  logic [TERM_W-1:0] edge_s;

  assign cw = o_r ? ih_r : iw_r;
  assign ch = o_r ? iw_r : ih_r;

  mrp_score u_score (
    .f     (f_r),
    .cw    (cw),
    .ch    (ch),
    .area  (area_r),
    .iwih  (iwih_r),
    .score (score_r),
    .mode  (cfg.mode),
    .fit   (sc_fit),
    .key1  (sc_key1),
    .key2  (sc_key2)
  );

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_wa] <= a_wd;
    a_rd_r <= a_mem[a_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_wa] <= b_wd;
    b_rd_r <= b_mem[b_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_wa] <= p_wd;
    p_rd_r <= p_mem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (u_we) u_mem[u_wa] <= u_wd;
    u_rd_r <= u_mem[u_ra];
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;
    cnt_nxt = cnt_r;  run_nxt = run_r;  scnt_nxt = scnt_r;  pcnt_nxt = pcnt_r;
    ucnt_nxt = ucnt_r;  uidx_nxt = uidx_r;
    o_nxt = o_r;  found_nxt = found_r;  rot_nxt = rot_r;
    pend_nxt = pend_r;  spill_nxt = spill_r;
    best1_nxt = best1_r;  best2_nxt = best2_r;
    pick_nxt = pick_r;  f_nxt = f_r;  ei_nxt = ei_r;
    area_nxt = area_r;  iwih_nxt = iwih_r;  iw_nxt = iw_r;  ih_nxt = ih_r;
    score_nxt = score_r;  dead_nxt = dead_r;  res_nxt = res_r;
    a_we = 1'b0;  a_wa = '0;  a_wd = a_rd_r;  a_ra = i_r[FREE_IW-1:0];
    b_we = 1'b0;  b_wa = '0;  b_wd = a_rd_r;  b_ra = i_r[FREE_IW-1:0];
    p_we = 1'b0;  p_wa = pcnt_r[FREE_IW-1:0];  p_wd = f_r;  p_ra = j_r[FREE_IW-1:0];
    u_we = 1'b0;  u_wa = ucnt_r[USED_IW-1:0];  u_wd = pick_r;
    u_ra = uidx_r[USED_IW-1:0];
    cand_fin = 1'b0;  adv = 1'b0;  pc = 1'b0;  inc = 1'b0;  dec = 1'b0;
    fw0 = coord_t'(a_rd_r.r - a_rd_r.l);
    fh0 = coord_t'(a_rd_r.b - a_rd_r.t);
    ex = coord_t'(f_r.l + cw);
    ey = coord_t'(f_r.t + ch);
    edge_s = '0;

    unique case (state_r)
      S_INIT: begin
        a_we = 1'b1;
        a_wa = '0;
        a_wd = '{l: '0, t: '0, r: clamp_dim(RESET_ATLAS_W), b: clamp_dim(RESET_ATLAS_H)};
        cnt_nxt = FREE_CW'(1);
        ucnt_nxt = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_word.kind) begin
            a_we = 1'b1;
            a_wa = '0;
            a_wd = '{l: '0, t: '0, r: clamp_dim(cfg.atlas_w), b: clamp_dim(cfg.atlas_h)};
            cnt_nxt = FREE_CW'(1);
            ucnt_nxt = '0;
            res_nxt = '{status: ST_OK, pos_x: '0, pos_y: '0, rotated: 1'b0};
            state_nxt = S_DONE;
          end else begin
            iw_nxt = in_word.item_width;
            ih_nxt = in_word.item_height;
            iwih_nxt = AREA_W'(in_word.item_width) * AREA_W'(in_word.item_height);
            found_nxt = 1'b0;
            i_nxt = '0;
            if (in_word.item_width == '0 || in_word.item_height == '0) begin
              res_nxt = '{status: ST_NOFIT, pos_x: '0, pos_y: '0, rotated: 1'b0};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SC_RD;
            end
          end
        end
      end
      S_SC_RD: begin
        if (i_r < cnt_r) begin
          state_nxt = S_SC_LAT;
        end else if (!found_r) begin
          res_nxt = '{status: ST_NOFIT, pos_x: '0, pos_y: '0, rotated: 1'b0};
          state_nxt = S_DONE;
        end else begin
          spill_nxt = 1'b0;
          i_nxt = '0;
          scnt_nxt = '0;
          pcnt_nxt = '0;
          run_nxt = cnt_r;
          dead_nxt = '0;
          state_nxt = S_SP_RD;
        end
      end
      S_SC_LAT: begin
        f_nxt = a_rd_r;
        area_nxt = AREA_W'(fw0) * AREA_W'(fh0);
        o_nxt = 1'b0;
        state_nxt = S_SC_CAND;
      end
      S_SC_CAND: begin
        if (!sc_fit) begin
          adv = 1'b1;
        end else if (cfg.mode == MODE_CONTACT) begin
          if (f_r.l == '0 || ex == clamp_dim(cfg.atlas_w)) edge_s = edge_s + TERM_W'(ch);
          if (f_r.t == '0 || ey == clamp_dim(cfg.atlas_h)) edge_s = edge_s + TERM_W'(cw);
          score_nxt = SCORE_W'(edge_s);
          uidx_nxt = '0;
          pend_nxt = 1'b0;
          state_nxt = S_CT;
        end else begin
          cand_fin = 1'b1;
          adv = 1'b1;
        end
      end
      S_CT: begin
        // one used rect read per cycle, accumulated in the next cycle
        if (pend_r) begin
          score_nxt = score_r + SCORE_W'(contact_term(u_rd_r, f_r.l, f_r.t, cw, ch));
        end
        if (uidx_r < ucnt_r) begin
          uidx_nxt = uidx_r + USED_CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cand_fin = 1'b1;
            adv = 1'b1;
          end
        end
      end
      S_SP_RD: begin
        if (i_r < cnt_r) begin
          state_nxt = S_SP_EVAL;
        end else begin
          j_nxt = '0;
          state_nxt = S_CP_RD;
        end
      end
      S_SP_EVAL: begin
        f_nxt = a_rd_r;
        if (!rect_hits(a_rd_r, pick_r)) begin
          b_we = 1'b1;
          b_wa = scnt_r[FREE_IW-1:0];
          b_wd = a_rd_r;
          scnt_nxt = scnt_r + FREE_CW'(1);
          i_nxt = i_r + FREE_CW'(1);
          state_nxt = S_SP_RD;
        end else begin
          k_nxt = '0;
          state_nxt = S_SP_PUSH;
        end
      end
      S_SP_PUSH: begin
        pc = push_cond(f_r, pick_r, k_r);
        p_wd = push_rect(f_r, pick_r, k_r);
        if (pc) begin
          if (run_r < FREE_CW'(MAX_FREE_RECTS)) begin
            p_we = 1'b1;
            pcnt_nxt = pcnt_r + FREE_CW'(1);
            inc = 1'b1;
          end else begin
            spill_nxt = 1'b1;
          end
        end
        // the split rect itself leaves after its last part
        dec = (k_r == 2'd3);
        run_nxt = run_r + FREE_CW'(inc) - FREE_CW'(dec);
        if (dec) begin
          i_nxt = i_r + FREE_CW'(1);
          state_nxt = S_SP_RD;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_CP_RD: begin
        if (j_r < pcnt_r) begin
          state_nxt = S_CP_WR;
        end else begin
          i_nxt = '0;
          state_nxt = S_PI_RD;
        end
      end
      S_CP_WR: begin
        b_we = 1'b1;
        b_wa = FREE_IW'(scnt_r + j_r);
        b_wd = p_rd_r;
        j_nxt = j_r + FREE_CW'(1);
        state_nxt = S_CP_RD;
      end
      S_PI_RD: begin
        if (i_r < run_r) begin
          if (dead_r[i_r[FREE_IW-1:0]]) i_nxt = i_r + FREE_CW'(1);
          else state_nxt = S_PI_LAT;
        end else begin
          i_nxt = '0;
          scnt_nxt = '0;
          state_nxt = S_KC_RD;
        end
      end
      S_PI_LAT: begin
        ei_nxt = b_rd_r;
        j_nxt = i_r + FREE_CW'(1);
        state_nxt = S_PJ_RD;
      end
      S_PJ_RD: begin
        b_ra = j_r[FREE_IW-1:0];
        if (j_r < run_r) begin
          if (dead_r[j_r[FREE_IW-1:0]]) j_nxt = j_r + FREE_CW'(1);
          else state_nxt = S_PJ_EVAL;
        end else begin
          i_nxt = i_r + FREE_CW'(1);
          state_nxt = S_PI_RD;
        end
      end
      S_PJ_EVAL: begin
        if (rect_inside(ei_r, b_rd_r)) begin
          dead_nxt[i_r[FREE_IW-1:0]] = 1'b1;
          i_nxt = i_r + FREE_CW'(1);
          state_nxt = S_PI_RD;
        end else begin
          if (rect_inside(b_rd_r, ei_r)) dead_nxt[j_r[FREE_IW-1:0]] = 1'b1;
          j_nxt = j_r + FREE_CW'(1);
          state_nxt = S_PJ_RD;
        end
      end
      S_KC_RD: begin
        if (i_r < run_r) begin
          state_nxt = S_KC_WR;
        end else begin
          cnt_nxt = scnt_r;
          state_nxt = S_REC;
        end
      end
      S_KC_WR: begin
        if (!dead_r[i_r[FREE_IW-1:0]]) begin
          a_we = 1'b1;
          a_wa = scnt_r[FREE_IW-1:0];
          a_wd = b_rd_r;
          scnt_nxt = scnt_r + FREE_CW'(1);
        end
        i_nxt = i_r + FREE_CW'(1);
        state_nxt = S_KC_RD;
      end
      S_REC: begin
        if (ucnt_r < USED_CW'(MAX_USED_RECTS)) begin
          u_we = 1'b1;
          ucnt_nxt = ucnt_r + USED_CW'(1);
        end
        res_nxt = '{status: spill_r ? ST_SPILL : ST_OK, pos_x: pick_r.l,
                    pos_y: pick_r.t, rotated: rot_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase

    // first best candidate wins ties
    if (cand_fin) begin
      if (!found_r || sc_key1 < best1_r || (sc_key1 == best1_r && sc_key2 < best2_r)) begin
        best1_nxt = sc_key1;
        best2_nxt = sc_key2;
        pick_nxt = '{l: f_r.l, t: f_r.t, r: ex, b: ey};
        rot_nxt = o_r;
        found_nxt = 1'b1;
      end
    end
    if (adv) begin
      if (!o_r && cfg.rot) begin
        o_nxt = 1'b1;
        state_nxt = S_SC_CAND;
      end else begin
        i_nxt = i_r + FREE_CW'(1);
        state_nxt = S_SC_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= FREE_CW'(1);
      ucnt_r  <= '0;
      found_r <= 1'b0;
      pend_r  <= 1'b0;
      spill_r <= 1'b0;
      dead_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ucnt_r  <= ucnt_nxt;
      found_r <= found_nxt;
      pend_r  <= pend_nxt;
      spill_r <= spill_nxt;
      dead_r  <= dead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;  j_r <= j_nxt;  k_r <= k_nxt;
    run_r <= run_nxt;  scnt_r <= scnt_nxt;  pcnt_r <= pcnt_nxt;
    uidx_r <= uidx_nxt;  o_r <= o_nxt;  rot_r <= rot_nxt;
    best1_r <= best1_nxt;  best2_r <= best2_nxt;
    pick_r <= pick_nxt;  f_r <= f_nxt;  ei_r <= ei_nxt;
    area_r <= area_nxt;  iwih_r <= iwih_nxt;  iw_r <= iw_nxt;  ih_r <= ih_nxt;
    score_r <= score_nxt;  res_r <= res_nxt;
  end

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_word  = res_r;

endmodule

// ===== rtl/maxrects_rect_packer_top.sv =====
// top level of the maxrects rectangle packer: config registers and result register
// depends on mrp_pkg and mrp_engine
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall   in_t  (kind, item_width, item_height)
//   out_     output     out_valid/out_stall out_t (status, pos_x, pos_y, rotated)
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a restart goes from idle straight to done; an insert scans the N free rects
// (both orientations with rotation), plus a pass over the used rects per fitting
// candidate in contact mode (one used rect per cycle), then splits each overlapped rect,
// copies the new parts, prunes the M free rects pairwise and compacts them.
// synchronous reset; after reset the S_INIT state writes the full atlas to the free table.
// in_stall is high whenever the engine is not idle, also while an item is at work;
// a finished word waits in the engine until the out register is free.
module maxrects_rect_packer_top import mrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic eng_ready, res_valid, res_take, start;
  out_t res_word;

  assign cfg_ready = 1'b1;
  assign start     = in_valid && eng_ready;
  assign in_stall  = !eng_ready;
  assign res_take  = res_valid && (!out_valid_r || !out_stall);

  mrp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .in_word   (in_data),
    .ready     (eng_ready),
    .res_valid (res_valid),
    .res_word  (res_word),
    .res_take  (res_take)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:   cfg_nxt.mode    = cfg_data[2:0];
        CFG_ROT:    cfg_nxt.rot     = cfg_data[0];
        CFG_ATLASW: cfg_nxt.atlas_w = coord_t'(cfg_data);
        CFG_ATLASH: cfg_nxt.atlas_h = coord_t'(cfg_data);
        default: ;
      endcase
    end
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{mode: MODE_TOPLEFT, rot: 1'b0, atlas_w: RESET_ATLAS_W,
                       atlas_h: RESET_ATLAS_H};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/maxrects_rect_packer_top_tb.sv =====
// testbench for maxrects_rect_packer_top: random and directed restart/insert words,
// with a cycle-free predictor of the packer and a scoreboard class for the results
// depends on mrp_pkg and the packer rtl
`timescale 1ns / 1ps

module maxrects_rect_packer_top_tb;
  import mrp_pkg::*;

  class rect_scoreboard;
    out_t pending[$];
    int   mismatches;

    function void note(out_t w);
      pending.insert(pending.size(), w);
    endfunction

    function void check(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d x %0d y %0d rot %0d",
                   got.status, got.pos_x, got.pos_y, got.rotated);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.pos_x !== want.pos_x ||
          got.pos_y !== want.pos_y || got.rotated !== want.rotated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want status %0d x %0d y %0d rot %0d, got %0d %0d %0d %0d",
                   want.status, want.pos_x, want.pos_y, want.rotated,
                   got.status, got.pos_x, got.pos_y, got.rotated);
      end
    endfunction
  endclass

  typedef struct {
    int unsigned l, t, r, b;
  } box_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rect_scoreboard placements;
  bit             quiet;

  // packer mirror
  box_t        free_tab[MAX_FREE_RECTS];
  int          free_n;
  box_t        used_tab[MAX_USED_RECTS];
  int          used_n;
  logic [2:0]  mode_q;
  logic        rot_q;
  coord_t      atlas_w_q;
  coord_t      atlas_h_q;
  bit          spilled;

  maxrects_rect_packer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned sat_dim(int unsigned v);
    return (v > MAX_COORD) ? MAX_COORD : v;
  endfunction

  function automatic void clear_atlas();
    free_tab[0] = '{0, 0, sat_dim(atlas_w_q), sat_dim(atlas_h_q)};
    free_n = 1;
    used_n = 0;
  endfunction

  function automatic int unsigned span_overlap(int unsigned a0, int unsigned a1,
                                               int unsigned b0, int unsigned b1);
    if (a1 < b0 || b1 < a0) return 0;
    return ((a1 < b1) ? a1 : b1) - ((a0 > b0) ? a0 : b0);
  endfunction

  function automatic int unsigned touch_len(int unsigned x, int unsigned y,
                                            int unsigned w, int unsigned h);
    int unsigned s;
    s = 0;
    if (x == 0 || x + w == sat_dim(atlas_w_q)) s += h;
    if (y == 0 || y + h == sat_dim(atlas_h_q)) s += w;
    for (int i = 0; i < used_n; i++) begin
      if (used_tab[i].l == x + w || used_tab[i].r == x)
        s += span_overlap(used_tab[i].t, used_tab[i].b, y, y + h);
      if (used_tab[i].t == y + h || used_tab[i].b == y)
        s += span_overlap(used_tab[i].l, used_tab[i].r, x, x + w);
    end
    return s;
  endfunction

  function automatic void add_free(box_t n);
    if (free_n < MAX_FREE_RECTS) begin
      free_tab[free_n] = n;
      free_n++;
    end else begin
      spilled = 1;
    end
  endfunction

  function automatic bit carve(box_t f, box_t u);
    box_t n;
    if (u.l >= f.r || u.r <= f.l || u.t >= f.b || u.b <= f.t) return 0;
    if (u.t > f.t && u.t < f.b) begin n = f; n.b = u.t; add_free(n); end
    if (u.b < f.b) begin n = f; n.t = u.b; add_free(n); end
    if (u.l > f.l && u.l < f.r) begin n = f; n.r = u.l; add_free(n); end
    if (u.r < f.r) begin n = f; n.l = u.r; add_free(n); end
    return 1;
  endfunction

  function automatic bit covered(box_t a, box_t b);
    return a.l >= b.l && a.t >= b.t && a.r <= b.r && a.b <= b.b;
  endfunction

  function automatic void drop_free(int k);
    for (int m = k; m < free_n - 1; m++) free_tab[m] = free_tab[m+1];
    free_n--;
  endfunction

  function automatic void commit_rect(box_t u);
    int num;
    num = free_n;
    for (int i = 0; i < num; i++) begin
      if (carve(free_tab[i], u)) begin
        drop_free(i);
        i--;
        num--;
      end
    end
    for (int i = 0; i < free_n; i++) begin
      for (int j = i + 1; j < free_n; j++) begin
        if (covered(free_tab[i], free_tab[j])) begin
          drop_free(i);
          i--;
          break;
        end
        if (covered(free_tab[j], free_tab[i])) begin
          drop_free(j);
          j--;
        end
      end
    end
    if (used_n < MAX_USED_RECTS) begin
      used_tab[used_n] = u;
      used_n++;
    end
  endfunction

  function automatic out_t pack_word(in_t w);
    out_t             res;
    longint unsigned  best1, best2, s1, s2;
    bit               found, rot;
    box_t             pick, f;
    int unsigned      iw, ih, fw, fh, cw, ch, dx, dy, sh, lg;
    res = '0;
    best1 = '1;
    best2 = '1;
    found = 0;
    rot = 0;
    pick = '{0, 0, 0, 0};
    if (w.kind) begin
      clear_atlas();
      return res;
    end
    iw = w.item_width;
    ih = w.item_height;
    if (iw != 0 && ih != 0) begin
      for (int i = 0; i < free_n; i++) begin
        f = free_tab[i];
        fw = f.r - f.l;
        fh = f.b - f.t;
        for (int o = 0; o < 2; o++) begin
          if (o == 1 && !rot_q) break;
          cw = o ? ih : iw;
          ch = o ? iw : ih;
          if (cw > fw || ch > fh) continue;
          dx = fw - cw;
          dy = fh - ch;
          sh = (dx < dy) ? dx : dy;
          lg = (dx < dy) ? dy : dx;
          case (mode_q)
            MODE_SHORT: begin s1 = sh; s2 = lg; end
            MODE_LONG:  begin s1 = lg; s2 = sh; end
            MODE_AREA: begin
              s1 = longint'(fw) * fh - longint'(iw) * ih;
              s2 = sh;
            end
            MODE_CONTACT: begin
              s1 = 64'hFFFF_FFFF - touch_len(f.l, f.t, cw, ch);
              s2 = 0;
            end
            default: begin s1 = f.t + ch; s2 = f.l; end
          endcase
          if (s1 < best1 || (s1 == best1 && s2 < best2)) begin
            best1 = s1;
            best2 = s2;
            pick = '{f.l, f.t, f.l + cw, f.t + ch};
            rot = (o != 0);
            found = 1;
          end
        end
      end
    end
    if (!found) begin
      res.status = ST_NOFIT;
      return res;
    end
    spilled = 0;
    commit_rect(pick);
    res.status  = spilled ? ST_SPILL : ST_OK;
    res.pos_x   = coord_t'(pick.l);
    res.pos_y   = coord_t'(pick.t);
    res.rotated = rot;
    return res;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:   mode_q = val[2:0];
      CFG_ROT:    rot_q = val[0];
      CFG_ATLASW: atlas_w_q = val;
      CFG_ATLASH: atlas_h_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(logic kind, int unsigned w, int unsigned h);
    in_t word;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    word.kind        = kind;
    word.item_width  = coord_t'(w);
    word.item_height = coord_t'(h);
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (in_stall);
    placements.note(pack_word(word));
  endtask

  // let the block go idle before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (placements.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_insert(int unsigned aw, int unsigned ah);
    int unsigned sel, w, h;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      w = $urandom_range(0, 8191);
      h = $urandom_range(0, 8191);
    end else if (sel == 1) begin
      w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 64);
      h = (w == 0) ? $urandom_range(0, 64) : 0;
    end else begin
      w = $urandom_range(1, (aw > 6) ? aw / 3 : 2);
      h = $urandom_range(1, (ah > 6) ? ah / 3 : 2);
    end
    send_word(1'b0, w, h);
  endtask

  task automatic run_phase(int items, int unsigned aw, int unsigned ah, logic [2:0] md,
                           logic rot);
    drain();
    write_reg(CFG_MODE, CFG_DATA_W'(md));
    write_reg(CFG_ROT, CFG_DATA_W'(rot));
    write_reg(CFG_ATLASW, CFG_DATA_W'(aw));
    write_reg(CFG_ATLASH, CFG_DATA_W'(ah));
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
    send_word(1'b1, $urandom_range(0, 8191), $urandom_range(0, 8191));
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 59) == 0)
        send_word(1'b1, $urandom_range(0, 8191), $urandom_range(0, 8191));
      else
        send_insert(sat_dim(aw), sat_dim(ah));
    end
  endtask

  // receiver side idling
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) placements.check(out_data);
  end

  initial begin
    #2s;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned aw, ah;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 0;
    placements = new();
    mode_q    = MODE_TOPLEFT;
    rot_q     = 1'b0;
    atlas_w_q = RESET_ATLAS_W;
    atlas_h_q = RESET_ATLAS_H;
    clear_atlas();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: reset settings, size extremes, full atlas, empty free table
    send_word(1'b0, 0, 0);
    send_word(1'b0, 0, 5);
    send_word(1'b0, 5, 0);
    send_word(1'b0, 8191, 1);
    send_word(1'b0, 1, 8191);
    send_word(1'b0, 4096, 4096);
    send_word(1'b0, 1024, 1024);
    send_word(1'b0, 1, 1);
    send_word(1'b1, 8191, 8191);
    send_word(1'b0, 1025, 3);
    send_word(1'b0, 100, 200);
    send_word(1'b0, 924, 10);
    send_word(1'b0, 300, 1024);
    send_word(1'b1, 0, 0);
    send_word(1'b0, 1024, 1);
    drain();
    // zero and saturating atlas sizes, rotation forced
    write_reg(CFG_ATLASW, CFG_DATA_W'(0));
    write_reg(CFG_ATLASH, CFG_DATA_W'(8191));
    send_word(1'b1, 0, 0);
    send_word(1'b0, 1, 1);
    drain();
    write_reg(CFG_ATLASW, CFG_DATA_W'(8191));
    write_reg(CFG_ROT, CFG_DATA_W'(1'b1));
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_CONTACT));
    send_word(1'b1, 0, 0);
    send_word(1'b0, 4096, 4095);
    send_word(1'b0, 2, 1);
    send_word(1'b0, 4096, 4096);

    // the used table fills up here
    run_phase(290, 4096, 4096, MODE_TOPLEFT, 1'b0);
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(0, 5))
        0: aw = $urandom_range(1, 16);
        1: aw = 4096;
        2: aw = $urandom_range(4097, 8191);
        3: aw = 1024;
        default: aw = $urandom_range(17, 4096);
      endcase
      ah = $urandom_range(0, 1) ? aw : $urandom_range(1, 4096);
      run_phase(62, aw, ah, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
    run_phase(60, 512, 512, MODE_CONTACT, 1'b1);
    // last stretch without idling
    quiet = 1;
    drain();
    run_phase(80, 256, 256, MODE_SHORT, 1'b1);

    in_valid <= 1'b0;
    while (placements.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (placements.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
